### hdl/mpm_pkg.sv
// Shared constants for the memory pressure monitor: field widths, mode, level and
// register index codes, hold-off windows and register reset values.
// No dependencies.
`timescale 1ns / 1ps

package mpm_pkg;

  localparam int BYTE_WIDTH_DEF  = 40;
  localparam int FRAME_WIDTH_DEF = 32;

  localparam int MODE_W      = 3;
  localparam int LEVEL_W     = 3;
  localparam int FRAC_BITS   = 16;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int ENABLE_W    = 2;
  localparam int CFG_INDEX_W = 3;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_USAGE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEANUP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PURGE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

  // Pressure levels.
  localparam logic [LEVEL_W-1:0] LEVEL_NONE     = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW      = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM   = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH     = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_CRITICAL = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLEANUP_LEVEL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PURGE_LEVEL   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_FRAC      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_FRAC   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_FRAC     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL_FRAC = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLES       = 3'd7;

  // Hold-off windows in frames.
  localparam int HOLD_CLEANUP = 60;
  localparam int HOLD_PURGE   = 120;

  // Register reset values.
  localparam longint unsigned CAPACITY_RESET      = 64'd1610612736;
  localparam longint unsigned CLEANUP_LEVEL_RESET = 64'd1342177280;
  localparam longint unsigned PURGE_LEVEL_RESET   = 64'd1530920960;
  localparam logic [FRAC_W-1:0]   LOW_FRAC_RESET      = 17'd39322;
  localparam logic [FRAC_W-1:0]   MEDIUM_FRAC_RESET   = 17'd49152;
  localparam logic [FRAC_W-1:0]   HIGH_FRAC_RESET     = 17'd55706;
  localparam logic [FRAC_W-1:0]   CRITICAL_FRAC_RESET = 17'd62259;
  localparam logic [ENABLE_W-1:0] ENABLES_RESET       = 2'd3;

endpackage

### hdl/mpm_cfg.sv
// Configuration registers of the memory pressure monitor and the registered
// pressure thresholds (capacity times each Q1.16 fraction). Uses mpm_pkg.
`timescale 1ns / 1ps

module mpm_cfg #(
  parameter int BYTE_WIDTH = mpm_pkg::BYTE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mpm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_WIDTH-1:0]           cfg_data,
  output logic [BYTE_WIDTH-1:0]           capacity,
  output logic [BYTE_WIDTH-1:0]           cleanup_level,
  output logic [BYTE_WIDTH-1:0]           purge_level,
  output logic [BYTE_WIDTH+mpm_pkg::FRAC_BITS:0] thr_low,
  output logic [BYTE_WIDTH+mpm_pkg::FRAC_BITS:0] thr_medium,
  output logic [BYTE_WIDTH+mpm_pkg::FRAC_BITS:0] thr_high,
  output logic [BYTE_WIDTH+mpm_pkg::FRAC_BITS:0] thr_critical,
  output logic [mpm_pkg::ENABLE_W-1:0]    enables
);
  import mpm_pkg::*;

  localparam int THR_W = BYTE_WIDTH + FRAC_W;

  logic [FRAC_W-1:0] low_frac;
  logic [FRAC_W-1:0] medium_frac;
  logic [FRAC_W-1:0] high_frac;
  logic [FRAC_W-1:0] critical_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= BYTE_WIDTH'(CAPACITY_RESET);
      cleanup_level <= BYTE_WIDTH'(CLEANUP_LEVEL_RESET);
      purge_level   <= BYTE_WIDTH'(PURGE_LEVEL_RESET);
      low_frac      <= LOW_FRAC_RESET;
      medium_frac   <= MEDIUM_FRAC_RESET;
      high_frac     <= HIGH_FRAC_RESET;
      critical_frac <= CRITICAL_FRAC_RESET;
      enables       <= ENABLES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY:      capacity      <= cfg_data;
        REG_CLEANUP_LEVEL: cleanup_level <= cfg_data;
        REG_PURGE_LEVEL:   purge_level   <= cfg_data;
        REG_LOW_FRAC:      low_frac      <= cfg_data[FRAC_W-1:0];
        REG_MEDIUM_FRAC:   medium_frac   <= cfg_data[FRAC_W-1:0];
        REG_HIGH_FRAC:     high_frac     <= cfg_data[FRAC_W-1:0];
        REG_CRITICAL_FRAC: critical_frac <= cfg_data[FRAC_W-1:0];
        REG_ENABLES:       enables       <= cfg_data[ENABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Thresholds only change with configuration, so they are recomputed every
  // cycle and registered behind the configuration registers after a write.
  always_ff @(posedge clk) begin
    thr_low      <= THR_W'(capacity) * THR_W'(low_frac);
    thr_medium   <= THR_W'(capacity) * THR_W'(medium_frac);
    thr_high     <= THR_W'(capacity) * THR_W'(high_frac);
    thr_critical <= THR_W'(capacity) * THR_W'(critical_frac);
  end

endmodule

### hdl/mpm_core.sv
// Monitor state and the single-pass evaluation of one item: pressure grading,
// cleanup and purge issue with hold-off, allocation check. Uses mpm_pkg.
`timescale 1ns / 1ps

module mpm_core #(
  parameter int BYTE_WIDTH  = mpm_pkg::BYTE_WIDTH_DEF,
  parameter int FRAME_WIDTH = mpm_pkg::FRAME_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [mpm_pkg::MODE_W-1:0]      mode,
  input  logic [BYTE_WIDTH-1:0]           amount_bytes,
  input  logic [BYTE_WIDTH-1:0]           capacity,
  input  logic [BYTE_WIDTH-1:0]           cleanup_level,
  input  logic [BYTE_WIDTH-1:0]           purge_level,
  input  logic [BYTE_WIDTH+mpm_pkg::FRAC_BITS:0] thr_low,
  input  logic [BYTE_WIDTH+mpm_pkg::FRAC_BITS:0] thr_medium,
  input  logic [BYTE_WIDTH+mpm_pkg::FRAC_BITS:0] thr_high,
  input  logic [BYTE_WIDTH+mpm_pkg::FRAC_BITS:0] thr_critical,
  input  logic [mpm_pkg::ENABLE_W-1:0]    enables,
  output logic [mpm_pkg::LEVEL_W-1:0]     pressure_grade,
  output logic                            cleanup_fired,
  output logic                            purge_fired,
  output logic                            over_limit,
  output logic [BYTE_WIDTH-1:0]           available_bytes,
  output logic                            allocation_fits,
  output logic [BYTE_WIDTH-1:0]           peak_bytes,
  output logic [FRAME_WIDTH-1:0]          cleanups_done,
  output logic [FRAME_WIDTH-1:0]          purges_done,
  output logic [FRAME_WIDTH-1:0]          frame_number
);
  import mpm_pkg::*;

  localparam int THR_W = BYTE_WIDTH + FRAC_W;

  logic [BYTE_WIDTH-1:0]  usage_now;
  logic [BYTE_WIDTH-1:0]  usage_peak;
  logic [LEVEL_W-1:0]     previous_level;
  logic [FRAME_WIDTH-1:0] frame_count;
  logic [FRAME_WIDTH-1:0] last_cleanup_at;
  logic [FRAME_WIDTH-1:0] last_purge_at;
  logic [FRAME_WIDTH-1:0] cleanup_total;
  logic [FRAME_WIDTH-1:0] purge_total;

  logic                   is_report;
  logic [BYTE_WIDTH-1:0]  usage_next;
  logic [THR_W-1:0]       usage_scaled;
  logic [LEVEL_W-1:0]     level;
  logic                   level_change;
  logic                   cleanup_ready;
  logic                   purge_ready;
  logic                   cleanup_try;
  logic                   purge_try;
  logic [BYTE_WIDTH:0]    fit_sum;

  assign is_report    = (mode == MODE_USAGE);
  assign usage_next   = is_report ? amount_bytes : usage_now;
  assign usage_scaled = {1'b0, usage_next, {FRAC_BITS{1'b0}}};

  // Exact compare of usage * 2^16 against capacity * fraction, highest first.
  always_comb begin
    if (usage_scaled >= thr_critical) begin
      level = LEVEL_CRITICAL;
    end else if (usage_scaled >= thr_high) begin
      level = LEVEL_HIGH;
    end else if (usage_scaled >= thr_medium) begin
      level = LEVEL_MEDIUM;
    end else if (usage_scaled >= thr_low) begin
      level = LEVEL_LOW;
    end else begin
      level = LEVEL_NONE;
    end
  end

  assign level_change  = is_report && (level != previous_level);
  assign cleanup_ready = enables[0] &&
                         ((frame_count - last_cleanup_at) >= FRAME_WIDTH'(HOLD_CLEANUP));
  assign purge_ready   = enables[1] &&
                         ((frame_count - last_purge_at) >= FRAME_WIDTH'(HOLD_PURGE));

  // Within one item every attempt sees the same frame count, so each action
  // fires at most once; a purge always brings a cleanup attempt with it.
  assign purge_try = (mode == MODE_PURGE) ||
                     (is_report && ((level_change && level == LEVEL_CRITICAL) ||
                                    usage_next >= purge_level));
  assign purge_fired = purge_try && purge_ready;

  assign cleanup_try = (mode == MODE_CLEANUP) || purge_fired ||
                       (is_report && ((level_change && level >= LEVEL_HIGH) ||
                                      usage_next >= cleanup_level));
  assign cleanup_fired = cleanup_try && cleanup_ready;

  assign fit_sum = {1'b0, usage_now} + {1'b0, amount_bytes};
  assign allocation_fits = (mode == MODE_QUERY) && (fit_sum <= {1'b0, capacity});

  assign pressure_grade  = level;
  assign over_limit      = usage_next > capacity;
  assign available_bytes = (usage_next >= capacity) ? '0 : capacity - usage_next;
  assign peak_bytes      = (is_report && usage_next > usage_peak) ? usage_next : usage_peak;
  assign cleanups_done   = cleanup_fired ? cleanup_total + 1'b1 : cleanup_total;
  assign purges_done     = purge_fired ? purge_total + 1'b1 : purge_total;
  assign frame_number    = (mode == MODE_TICK) ? frame_count + 1'b1 : frame_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      usage_now       <= '0;
      usage_peak      <= '0;
      previous_level  <= LEVEL_NONE;
      frame_count     <= '0;
      last_cleanup_at <= '0;
      last_purge_at   <= '0;
      cleanup_total   <= '0;
      purge_total     <= '0;
    end else if (advance) begin
      usage_now     <= usage_next;
      usage_peak    <= peak_bytes;
      frame_count   <= frame_number;
      cleanup_total <= cleanups_done;
      purge_total   <= purges_done;
      if (level_change) begin
        previous_level <= level;
      end
      if (cleanup_fired) begin
        last_cleanup_at <= frame_count;
      end
      if (purge_fired) begin
        last_purge_at <= frame_count;
      end
    end
  end

endmodule

### hdl/memory_pressure_monitor.sv
// Top level of the memory pressure monitor: stream ports, input and result
// registers, configuration block and evaluation core. Uses mpm_pkg, mpm_cfg, mpm_core.
`timescale 1ns / 1ps

// The monitor takes one item per clock cycle while m_tready does not stall the
// result register, and returns exactly one result item for each. An accepted
// item sits in the input register, where the core grades it against the stored
// state and updates that state, and its result is loaded into the output
// register when the item advances, while the next items keep flowing in behind
// it. The mode travels on s_tuser and the byte amount on s_tdata.
// The pressure thresholds are products of capacity and each fraction, held in
// registers that follow the configuration registers after a write.

module memory_pressure_monitor #(
  parameter int BYTE_WIDTH  = mpm_pkg::BYTE_WIDTH_DEF,
  parameter int FRAME_WIDTH = mpm_pkg::FRAME_WIDTH_DEF,
  localparam int IN_W       = ((BYTE_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS   = mpm_pkg::LEVEL_W + 4 + 2 * BYTE_WIDTH + 3 * FRAME_WIDTH,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // amount_bytes
  input  logic [IN_W-1:0]                 s_tdata,
  // mode
  input  logic [mpm_pkg::MODE_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pressure grade, cleanup_fired, purge_fired, over_limit, available_bytes,
  // allocation_fits, peak_bytes, cleanups_done, purges_done, frame_number
  output logic [OUT_W-1:0]                m_tdata,
  input  logic                            cfg_we,
  input  logic [mpm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_WIDTH-1:0]           cfg_data
);
  import mpm_pkg::*;

  localparam int THR_W = BYTE_WIDTH + FRAC_W;

  logic                   in_valid;
  logic [MODE_W-1:0]      in_mode;
  logic [BYTE_WIDTH-1:0]  in_amount;
  logic                   accept;
  logic                   advance;

  logic [BYTE_WIDTH-1:0]  capacity;
  logic [BYTE_WIDTH-1:0]  cleanup_level;
  logic [BYTE_WIDTH-1:0]  purge_level;
  logic [THR_W-1:0]       thr_low;
  logic [THR_W-1:0]       thr_medium;
  logic [THR_W-1:0]       thr_high;
  logic [THR_W-1:0]       thr_critical;
  logic [ENABLE_W-1:0]    enables;

  logic [LEVEL_W-1:0]     pressure_grade;
  logic                   cleanup_fired;
  logic                   purge_fired;
  logic                   over_limit;
  logic [BYTE_WIDTH-1:0]  available_bytes;
  logic                   allocation_fits;
  logic [BYTE_WIDTH-1:0]  peak_bytes;
  logic [FRAME_WIDTH-1:0] cleanups_done;
  logic [FRAME_WIDTH-1:0] purges_done;
  logic [FRAME_WIDTH-1:0] frame_number;

  // The item in the input register moves on whenever the result register is
  // empty or being emptied this cycle.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!in_valid || advance);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_mode   <= s_tuser;
      in_amount <= s_tdata[BYTE_WIDTH-1:0];
    end
    if (advance) begin
      m_tdata <= OUT_W'({frame_number, purges_done, cleanups_done, peak_bytes,
                         allocation_fits, available_bytes, over_limit,
                         purge_fired, cleanup_fired, pressure_grade});
    end
  end

  mpm_cfg #(
    .BYTE_WIDTH (BYTE_WIDTH)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .capacity      (capacity),
    .cleanup_level (cleanup_level),
    .purge_level   (purge_level),
    .thr_low       (thr_low),
    .thr_medium    (thr_medium),
    .thr_high      (thr_high),
    .thr_critical  (thr_critical),
    .enables       (enables)
  );

  mpm_core #(
    .BYTE_WIDTH  (BYTE_WIDTH),
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .mode            (in_mode),
    .amount_bytes    (in_amount),
    .capacity        (capacity),
    .cleanup_level   (cleanup_level),
    .purge_level     (purge_level),
    .thr_low         (thr_low),
    .thr_medium      (thr_medium),
    .thr_high        (thr_high),
    .thr_critical    (thr_critical),
    .enables         (enables),
    .pressure_grade  (pressure_grade),
    .cleanup_fired   (cleanup_fired),
    .purge_fired     (purge_fired),
    .over_limit      (over_limit),
    .available_bytes (available_bytes),
    .allocation_fits (allocation_fits),
    .peak_bytes      (peak_bytes),
    .cleanups_done   (cleanups_done),
    .purges_done     (purges_done),
    .frame_number    (frame_number)
  );

endmodule
